/* sv/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dhfk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_pkg
// Constants, types and fixed-point helpers of the DH chain kinematics block.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int MAX_JOINTS    = 16;
    localparam int ROT_FRAC_BITS = 14;
    localparam int JIDX_W        = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 48;
    localparam int SIN_SH = 30 - ROT_FRAC_BITS;

    localparam logic signed [15:0] ROT_ONE16 = 16'(1 << ROT_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ROT_ONE_W = ACC_W'(1) << ROT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (ROT_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] POS_MAX_W = ACC_W'(134217727);
    localparam logic signed [ACC_W-1:0] POS_MIN_W = -ACC_W'(134217728);

    localparam logic [MUL_W-1:0] HALF_PI_Q30 = MUL_W'(64'd1686629713);
    localparam logic [30:0]      T_ONE       = 31'(1) << 30;

    // reciprocal multipliers for the series divisors 110, 72, 42, 20, 6
    localparam logic [MUL_W-1:0] DIV_MAGIC [5] = '{
        MUL_W'(64'd4997780127), MUL_W'(64'd7635497416), MUL_W'(64'd6544712071),
        MUL_W'(64'd6871947674), MUL_W'(64'd5726623062)
    };
    localparam logic [6:0] DIV_SHIFT [5] = '{7'd39, 7'd39, 7'd38, 7'd37, 7'd35};

    // sine and link sequence steps
    localparam logic [3:0] STEP_PHI  = 4'd0;
    localparam logic [3:0] STEP_PHI2 = 4'd1;
    localparam logic [3:0] STEP_LAST = 4'd12;
    localparam logic [3:0] LINK_LAST = 4'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_LINK,
        S_POS,
        S_ROT,
        S_OUT
    } t_state;

    // floor((v + half) / 2^ROT_FRAC_BITS)
    function automatic logic signed [ACC_W-1:0] f_rnd(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v + RND_HALF;
        return s >>> ROT_FRAC_BITS;
    endfunction

    function automatic logic signed [15:0] f_sat_one(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ROT_ONE_W) begin
            r = ROT_ONE16;
        end else if (v < -ROT_ONE_W) begin
            r = -ROT_ONE16;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic logic signed [27:0] f_sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [27:0] r;
        if (v > POS_MAX_W) begin
            r = 28'(POS_MAX_W);
        end else if (v < POS_MIN_W) begin
            r = 28'(POS_MIN_W);
        end else begin
            r = 28'(v);
        end
        return r;
    endfunction

    // row-major index of a 3x3 matrix
    function automatic logic [3:0] f_idx(input logic [1:0] row, input logic [1:0] col);
        return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage
`default_nettype wire

/* sv/dh_chain_forward_kinematics.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dh_chain_forward_kinematics
// Chains modified DH joints into a base-frame rotation and position.
//
// channel  direction  handshake           payload
// input    in         i_valid / o_ready   first_joint, link_length, link_offset,
//                                         link_twist, joint_angle
// output   out        o_valid / i_ready   pos_x..pos_z, rot_00..rot_22
//
// one shared 34x34 multiplier does all 94 products, each with an issue and a
// writeback step: 52 for four sines, 6 link, 9 position, 27 rotation
// o_ready returns the cycle after the result is loaded, so no new joint is
// taken while one is still in progress
// a result still held in the output register stalls that load
// reset restores the identity rotation and zero position
// ----------------------------------------------------------------------------
module dh_chain_forward_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_first_joint,
    input  logic signed [23:0] i_link_length,
    input  logic signed [23:0] i_link_offset,
    input  logic [15:0]        i_link_twist,
    input  logic [15:0]        i_joint_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [27:0] o_pos_x,
    output logic signed [27:0] o_pos_y,
    output logic signed [27:0] o_pos_z,
    output logic signed [15:0] o_rot_00,
    output logic signed [15:0] o_rot_01,
    output logic signed [15:0] o_rot_02,
    output logic signed [15:0] o_rot_10,
    output logic signed [15:0] o_rot_11,
    output logic signed [15:0] o_rot_12,
    output logic signed [15:0] o_rot_20,
    output logic signed [15:0] o_rot_21,
    output logic signed [15:0] o_rot_22
);
    import dhfk_pkg::*;

    t_state r_state, n_state;
    logic r_ph, n_ph;
    logic [3:0] r_step, n_step;
    logic [1:0] r_ang, n_ang, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [JIDX_W-1:0] r_jidx, n_jidx;
    logic signed [23:0] r_len, n_len, r_off, n_off;
    logic [15:0] r_twist, n_twist, r_theta, n_theta;
    logic [30:0] r_phi, n_phi, r_t, n_t;
    logic [31:0] r_phi2, n_phi2, r_v, n_v;
    logic signed [15:0] r_trig [4];
    logic signed [15:0] n_trig [4];
    logic signed [15:0] r_link [9];
    logic signed [15:0] n_link [9];
    logic signed [24:0] r_lp [3];
    logic signed [24:0] n_lp [3];
    logic signed [15:0] r_rot [9];
    logic signed [15:0] n_rot [9];
    logic signed [15:0] r_nrot [9];
    logic signed [15:0] n_nrot [9];
    logic signed [27:0] r_pos [3];
    logic signed [27:0] n_pos [3];
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic r_ovalid, n_ovalid;
    logic signed [27:0] r_opos [3];
    logic signed [27:0] n_opos [3];
    logic signed [15:0] r_orot [9];
    logic signed [15:0] n_orot [9];

    logic signed [MUL_W-1:0] op_a, op_b;
    logic [15:0] ang_val;
    logic [14:0] ang_x;
    logic [2:0] hsel;
    logic [PROD_W-1:0] prod_u, quo_full;
    logic [31:0] sin_r, sin_rs;
    logic [15:0] sin_mag;
    logic signed [15:0] sin_q;
    logic signed [ACC_W-1:0] acc_sum, rnd_v;
    logic [3:0] ra_idx, rb_idx;
    logic slot_free;

    // sine datapath helpers
    assign ang_val  = (r_ang[1] ? r_theta : r_twist) + (r_ang[0] ? 16'h4000 : 16'h0000);
    assign ang_x    = ang_val[14] ? (15'd16384 - {1'b0, ang_val[13:0]})
                                  : {1'b0, ang_val[13:0]};
    assign hsel     = 3'(r_step[3:1] - 3'd1);
    assign prod_u   = r_prod;
    assign quo_full = prod_u >> DIV_SHIFT[hsel];
    assign sin_r    = r_prod[61:30];
    assign sin_rs   = (sin_r + (32'(1) << (SIN_SH - 1))) >> SIN_SH;
    assign sin_mag  = (sin_rs > 32'(ROT_ONE16)) ? ROT_ONE16 : sin_rs[15:0];
    assign sin_q    = ang_val[15] ? -$signed(sin_mag) : $signed(sin_mag);

    assign acc_sum  = r_acc + $signed(r_prod[ACC_W-1:0]);
    assign rnd_v    = f_rnd(acc_sum);
    assign ra_idx   = f_idx(r_i, (r_state == S_ROT) ? r_k : r_j);
    assign rb_idx   = f_idx(r_k, r_j);
    assign slot_free = !r_ovalid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_step   = r_step;
        n_ang    = r_ang;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_jidx   = r_jidx;
        n_len    = r_len;
        n_off    = r_off;
        n_twist  = r_twist;
        n_theta  = r_theta;
        n_phi    = r_phi;
        n_phi2   = r_phi2;
        n_v      = r_v;
        n_t      = r_t;
        n_trig   = r_trig;
        n_link   = r_link;
        n_lp     = r_lp;
        n_rot    = r_rot;
        n_nrot   = r_nrot;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_opos   = r_opos;
        n_orot   = r_orot;
        n_ovalid = r_ovalid && !i_ready;
        o_ready  = (r_state == S_IDLE);
        op_a     = '0;
        op_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_len   = i_link_length;
                    n_off   = i_link_offset;
                    n_twist = i_link_twist;
                    n_theta = i_joint_angle;
                    n_acc   = '0;
                    n_ph    = 1'b0;
                    n_step  = STEP_PHI;
                    n_ang   = 2'd0;
                    n_state = S_TRIG;
                    if (i_first_joint) begin
                        n_jidx = '0;
                        n_pos[0] = '0;
                        n_pos[1] = '0;
                        n_pos[2] = '0;
                        for (int e = 0; e < 9; e++) begin
                            n_rot[e] = (e == 0 || e == 4 || e == 8) ? ROT_ONE16 : '0;
                        end
                    end else if (r_jidx < JIDX_W'(MAX_JOINTS - 1)) begin
                        n_jidx = r_jidx + JIDX_W'(1);
                    end
                end
            end

            S_TRIG: begin
                case (r_step)
                    STEP_PHI: begin
                        op_a = $signed({19'b0, ang_x});
                        op_b = $signed(HALF_PI_Q30);
                    end
                    STEP_PHI2: begin
                        op_a = $signed({3'b0, r_phi});
                        op_b = $signed({3'b0, r_phi});
                    end
                    STEP_LAST: begin
                        op_a = $signed({3'b0, r_phi});
                        op_b = $signed({3'b0, r_t});
                    end
                    default: begin
                        // odd steps divide by a series constant, even ones scale by phi^2
                        if (r_step[0]) begin
                            op_a = $signed({2'b0, r_v});
                            op_b = $signed(DIV_MAGIC[hsel]);
                        end else begin
                            op_a = $signed({2'b0, r_phi2});
                            op_b = $signed({3'b0, r_t});
                        end
                    end
                endcase
                n_ph = !r_ph;
                if (r_ph) begin
                    n_step = r_step + 4'd1;
                    case (r_step)
                        STEP_PHI: begin
                            n_phi = r_prod[44:14];
                        end
                        STEP_PHI2: begin
                            n_phi2 = r_prod[61:30];
                            n_t    = T_ONE;
                        end
                        STEP_LAST: begin
                            n_trig[r_ang] = sin_q;
                            n_step = STEP_PHI;
                            n_ang  = r_ang + 2'd1;
                            if (r_ang == 2'd3) begin
                                n_state = S_LINK;
                            end
                        end
                        default: begin
                            if (r_step[0]) begin
                                n_t = T_ONE - quo_full[30:0];
                            end else begin
                                n_v = r_prod[61:30];
                            end
                        end
                    endcase
                end
            end

            S_LINK: begin
                // trig order: sin alpha, cos alpha, sin theta, cos theta
                op_a = MUL_W'(r_step[2] ? $signed(r_off) : $signed(r_trig[{1'b1, r_step[0]}]));
                if (r_step[2]) begin
                    op_b = MUL_W'(r_trig[{1'b0, r_step[0]}]);
                end else begin
                    op_b = MUL_W'(r_trig[{1'b0, !r_step[1]}]);
                end
                n_ph = !r_ph;
                if (r_ph) begin
                    n_step = r_step + 4'd1;
                    case (r_step)
                        4'd0: n_link[3] = f_sat_one(rnd_v);
                        4'd1: n_link[4] = f_sat_one(rnd_v);
                        4'd2: n_link[6] = f_sat_one(rnd_v);
                        4'd3: n_link[7] = f_sat_one(rnd_v);
                        4'd4: n_lp[1]   = 25'(-rnd_v);
                        default: begin
                            n_lp[2]   = 25'(rnd_v);
                            n_lp[0]   = 25'(r_len);
                            n_link[0] = r_trig[3];
                            n_link[1] = -r_trig[2];
                            n_link[2] = '0;
                            n_link[5] = -r_trig[0];
                            n_link[8] = r_trig[1];
                        end
                    endcase
                    if (r_step == LINK_LAST) begin
                        n_state = S_POS;
                        n_i = 2'd0;
                        n_j = 2'd0;
                    end
                end
            end

            S_POS: begin
                op_a = MUL_W'(r_rot[ra_idx]);
                op_b = MUL_W'(r_lp[r_j]);
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_j == 2'd2) begin
                        n_pos[r_i] = f_sat_pos(ACC_W'(r_pos[r_i]) + rnd_v);
                        n_acc = '0;
                        n_j   = 2'd0;
                        n_i   = r_i + 2'd1;
                        if (r_i == 2'd2) begin
                            n_i = 2'd0;
                            n_k = 2'd0;
                            n_state = S_ROT;
                        end
                    end else begin
                        n_acc = acc_sum;
                        n_j   = r_j + 2'd1;
                    end
                end
            end

            S_ROT: begin
                op_a = MUL_W'(r_rot[ra_idx]);
                op_b = MUL_W'(r_link[rb_idx]);
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_k == 2'd2) begin
                        n_nrot[f_idx(r_i, r_j)] = f_sat_one(rnd_v);
                        n_acc = '0;
                        n_k   = 2'd0;
                        n_j   = r_j + 2'd1;
                        if (r_j == 2'd2) begin
                            n_j = 2'd0;
                            n_i = r_i + 2'd1;
                            if (r_i == 2'd2) begin
                                n_state = S_OUT;
                            end
                        end
                    end else begin
                        n_acc = acc_sum;
                        n_k   = r_k + 2'd1;
                    end
                end
            end

            S_OUT: begin
                if (slot_free) begin
                    n_opos   = r_pos;
                    n_orot   = r_nrot;
                    n_rot    = r_nrot;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_prod = op_a * op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_ovalid <= 1'b0;
            r_jidx   <= '0;
            for (int e = 0; e < 3; e++) begin
                r_pos[e] <= '0;
            end
            for (int e = 0; e < 9; e++) begin
                r_rot[e] <= (e == 0 || e == 4 || e == 8) ? ROT_ONE16 : '0;
            end
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
            r_jidx   <= n_jidx;
            r_pos    <= n_pos;
            r_rot    <= n_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_ang   <= n_ang;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_len   <= n_len;
        r_off   <= n_off;
        r_twist <= n_twist;
        r_theta <= n_theta;
        r_phi   <= n_phi;
        r_phi2  <= n_phi2;
        r_v     <= n_v;
        r_t     <= n_t;
        r_trig  <= n_trig;
        r_link  <= n_link;
        r_lp    <= n_lp;
        r_nrot  <= n_nrot;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_opos  <= n_opos;
        r_orot  <= n_orot;
    end

    assign o_valid  = r_ovalid;
    assign o_pos_x  = r_opos[0];
    assign o_pos_y  = r_opos[1];
    assign o_pos_z  = r_opos[2];
    assign o_rot_00 = r_orot[0];
    assign o_rot_01 = r_orot[1];
    assign o_rot_02 = r_orot[2];
    assign o_rot_10 = r_orot[3];
    assign o_rot_11 = r_orot[4];
    assign o_rot_12 = r_orot[5];
    assign o_rot_20 = r_orot[6];
    assign o_rot_21 = r_orot[7];
    assign o_rot_22 = r_orot[8];

endmodule
`default_nettype wire

/* sv/dhfk_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level checks of the DH chain kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhfk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [27:0] o_pos_x,
    input logic signed [15:0] o_rot_00,
    input logic signed [15:0] o_rot_11,
    input logic signed [15:0] o_rot_22
);
    import dhfk_pkg::*;

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_pos_x) && $stable(o_rot_00), "output changed while stalled")

    // diagonal entries stay within plus or minus one
    `ASSERT_SAME(a_rot_range, i_clk, i_rst_n, o_valid, (o_rot_00 <= ROT_ONE16) && (o_rot_00 >= -ROT_ONE16) && (o_rot_11 <= ROT_ONE16) && (o_rot_11 >= -ROT_ONE16) && (o_rot_22 <= ROT_ONE16) && (o_rot_22 >= -ROT_ONE16), "rotation entry out of range")

    // one joint at a time: busy right after a transfer in
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready right after input transfer")

    // a new result cannot appear the cycle after a joint is taken
    `ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_valid && o_ready && !o_valid, !o_valid, "result too early")

endmodule

bind dh_chain_forward_kinematics dhfk_checker u_dhfk_checker (.*);
`default_nettype wire
